[hw/rtl/bgfb_pkg.sv]
// Shared types and constants for the bit-plane glyph frame buffer.
// No dependencies; every other file of the block but the checker imports this package.
`default_nettype none

package bgfb_pkg;

  // Default matrix size
  localparam int unsigned COLUMNS_DEF = 64;
  localparam int unsigned ROWS_DEF    = 16;

  // Field widths of one item and one result
  localparam int unsigned OP_W    = 3;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned GW_W    = 5;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned PLANES  = 3;
  localparam int unsigned WIDX_W  = 4;   // word column within a 256-pixel row

  // Opcodes carried by an item
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_DRAW  = 3'd1,
    OP_SET   = 3'd2,
    OP_CLR   = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // Command classes handed from the front end to the back end
  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_CLEAR = 3'd1,
    K_DRAW  = 3'd2,
    K_SET   = 3'd3,
    K_CLR   = 3'd4,
    K_READ  = 3'd5
  } kind_t;

  // One decoded command: up to two word masks, applied to each selected plane
  typedef struct packed {
    kind_t               kind;
    logic                oor;
    logic [PLANES-1:0]   planes;
    logic [WIDX_W-1:0]   word0;
    logic [POS_W-1:0]    y;
    logic [WORD_W-1:0]   mask0;
    logic [WORD_W-1:0]   mask1;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/bgfb_in_if.sv]
// Input channel of the frame buffer: valid/ready handshake and item fields.
// Depends on bgfb_pkg for the field widths.
`default_nettype none

interface bgfb_in_if
  import bgfb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [WORD_W-1:0]  row_bits;
  logic [GW_W-1:0]    glyph_width;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [LEVEL_W-1:0] level;
  logic [PLANE_W-1:0] plane;

  modport source (
    output valid, opcode, row_bits, glyph_width, pos_x, pos_y, level, plane,
    input  ready
  );
  modport sink (
    input  valid, opcode, row_bits, glyph_width, pos_x, pos_y, level, plane,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/bgfb_out_if.sv]
// Result channel of the frame buffer: valid/ready handshake and result fields.
// Depends on bgfb_pkg for the field widths.
`default_nettype none

interface bgfb_out_if
  import bgfb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_word;
  logic              out_of_range;

  modport source (
    output valid, read_word, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, read_word, out_of_range,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/bgfb_front.sv]
// Front end: accepts items, checks addresses and builds the word masks.
// Depends on bgfb_pkg and bgfb_in_if; feeds the command queue.
`default_nettype none

module bgfb_front
  import bgfb_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  bgfb_in_if.sink    in_chan,
  input  wire logic  q_full,
  input  wire logic  init_busy,
  output logic       push,
  output cmd_t       cmd
);

  localparam int unsigned FULL_WORDS = COLUMNS / 16;
  localparam int unsigned REM_COLS   = COLUMNS % 16;

  // Columns of word k that lie inside the matrix, leftmost pixel in bit 15
  function automatic logic [WORD_W-1:0] col_mask(input logic [WIDX_W-1:0] k);
    logic [WIDX_W:0] k_ext;
    k_ext = {1'b0, k};
    if (k_ext < (WIDX_W+1)'(FULL_WORDS)) begin
      col_mask = '1;
    end else if (k_ext == (WIDX_W+1)'(FULL_WORDS)) begin
      col_mask = ~(16'hFFFF >> REM_COLS);
    end else begin
      col_mask = '0;
    end
  endfunction

  logic                x_ok, y_ok, p_ok, px_ok;
  logic [GW_W-1:0]     wsat;
  logic [WORD_W:0]     gmask;
  logic [WORD_W-1:0]   eff_bits, rev_bits, pix_mask;
  logic [2*WORD_W-1:0] line;
  logic [WIDX_W-1:0]   k0, k1;
  logic [PLANES-1:0]   plane_sel;

  // Accept whenever the queue has room and the store is not being swept
  assign in_chan.ready = !q_full && !init_busy;
  assign push          = in_chan.valid && in_chan.ready;

  // Range checks
  assign x_ok  = {1'b0, in_chan.pos_x} < (POS_W+1)'(COLUMNS);
  assign y_ok  = {1'b0, in_chan.pos_y} < (POS_W+1)'(ROWS);
  assign p_ok  = in_chan.plane != 2'd3;
  assign px_ok = x_ok && y_ok && p_ok;

  // Saturate the glyph width and keep only the bits in use
  assign wsat     = (in_chan.glyph_width > GW_W'(16)) ? GW_W'(16) : in_chan.glyph_width;
  assign gmask    = ((WORD_W+1)'(1) << wsat) - (WORD_W+1)'(1);
  assign eff_bits = in_chan.row_bits & gmask[WORD_W-1:0];

  // Reverse so that glyph bit 0 becomes the leftmost pixel
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      rev_bits[WORD_W-1-i] = eff_bits[i];
    end
  end

  // Spread the row over two adjacent words; the word index wraps at 256 columns
  assign line      = {rev_bits, {WORD_W{1'b0}}} >> in_chan.pos_x[3:0];
  assign k0        = in_chan.pos_x[7:4];
  assign k1        = k0 + WIDX_W'(1);
  assign pix_mask  = 16'h8000 >> in_chan.pos_x[3:0];
  assign plane_sel = PLANES'(1) << in_chan.plane;

  // Classify the item
  always_comb begin
    cmd        = '0;
    cmd.kind   = K_NOP;
    cmd.word0  = k0;
    cmd.y      = in_chan.pos_y;
    unique case (in_chan.opcode)
      OP_CLEAR: begin
        cmd.kind = K_CLEAR;
      end
      OP_DRAW: begin
        cmd.kind      = K_DRAW;
        cmd.planes[0] = in_chan.level[2];
        cmd.planes[1] = in_chan.level[1];
        cmd.planes[2] = in_chan.level[0];
        if (y_ok) begin
          cmd.mask0 = line[2*WORD_W-1:WORD_W] & col_mask(k0);
          cmd.mask1 = line[WORD_W-1:0] & col_mask(k1);
        end
      end
      OP_SET, OP_CLR, OP_READ: begin
        if (px_ok) begin
          cmd.kind   = (in_chan.opcode == OP_SET) ? K_SET :
                       (in_chan.opcode == OP_CLR) ? K_CLR : K_READ;
          cmd.planes = plane_sel;
          cmd.mask0  = pix_mask;
        end else begin
          cmd.oor = 1'b1;
        end
      end
      default: begin
        cmd.kind = K_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bgfb_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on bgfb_pkg for the command type.
`default_nettype none

module bgfb_queue
  import bgfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty = cnt_r == 2'd0;
  assign full  = cnt_r == 2'd2;
  assign head  = slot_r[rp_r];

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bgfb_back.sv]
// Back end: owns the frame store, runs read-modify-write, sweeps and reads,
// and holds the result register. Depends on bgfb_pkg and bgfb_out_if.
`default_nettype none

module bgfb_back
  import bgfb_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cmd_t       head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       init_busy,
  bgfb_out_if.source out_chan
);

  localparam int unsigned WPR   = (COLUMNS + 15) / 16;
  localparam int unsigned WB    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int unsigned YB    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AW    = YB + WB + 2;
  localparam int unsigned DEPTH = PLANES << (YB + WB);
  localparam int unsigned SLOTS = 2 * PLANES;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_ACC   = 5'b01000,
    S_WR    = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [SLOTS-1:0]  pend_r, pend_nxt;
  logic              msel_r, msel_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [WORD_W-1:0] oword_r, oword_nxt;
  logic              ooor_r, ooor_nxt;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] wdata;

  logic [SLOTS-1:0]  head_pend;
  logic [2:0]        slot;
  logic [WIDX_W-1:0] widx;
  logic [AW-1:0]     sel_addr;
  logic [WORD_W-1:0] cur_mask;

  assign init_busy             = state_r == S_INIT;
  assign out_chan.valid        = ovalid_r;
  assign out_chan.read_word    = oword_r;
  assign out_chan.out_of_range = ooor_r;

  // Word accesses a command needs: one slot per plane and word
  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      head_pend[2*p]   = head.planes[p] && (head.mask0 != '0);
      head_pend[2*p+1] = head.planes[p] && (head.mask1 != '0);
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (pend_r[s]) begin
        slot = 3'(s);
      end
    end
  end

  assign widx     = slot[0] ? (cmd_r.word0 + WIDX_W'(1)) : cmd_r.word0;
  assign sel_addr = {slot[2:1], cmd_r.y[YB-1:0], widx[WB-1:0]};
  assign cur_mask = msel_r ? cmd_r.mask1 : cmd_r.mask0;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    pend_nxt   = pend_r;
    msel_nxt   = msel_r;
    cmd_nxt    = cmd_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;
    ooor_nxt   = ooor_r;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    wdata      = '0;

    // Drop the result once taken
    if (ovalid_r && out_chan.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT, S_SWEEP: begin
        mem_we = 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          addr_nxt  = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_ACC;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = head;
          pend_nxt  = head_pend;
          res_nxt   = '0;
          addr_nxt  = '0;
          state_nxt = (head.kind == K_CLEAR) ? S_SWEEP : S_ACC;
        end
      end
      S_ACC: begin
        if (pend_r == '0) begin
          if (!ovalid_r || out_chan.ready) begin
            ovalid_nxt = 1'b1;
            oword_nxt  = res_r;
            ooor_nxt   = cmd_r.oor;
            state_nxt  = S_IDLE;
          end
        end else begin
          mem_re         = 1'b1;
          addr_nxt       = sel_addr;
          msel_nxt       = slot[0];
          pend_nxt[slot] = 1'b0;
          state_nxt      = S_WR;
        end
      end
      S_WR: begin
        if (cmd_r.kind == K_READ) begin
          res_nxt = rdata_r;
        end else begin
          mem_we = 1'b1;
          wdata  = (cmd_r.kind == K_CLR) ? (rdata_r & ~cur_mask) : (rdata_r | cur_mask);
        end
        state_nxt = S_ACC;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      addr_r   <= '0;
      pend_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    msel_r  <= msel_nxt;
    cmd_r   <= cmd_nxt;
    res_r   <= res_nxt;
    oword_r <= oword_nxt;
    ooor_r  <= ooor_nxt;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[sel_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bitplane_glyph_framebuffer_top.sv]
// Bit-plane glyph frame buffer. A rejected or unused opcode touches no word, a pixel
// set, clear or read touches one word, a draw up to two words in each of three planes,
// and clear all writes all 3 * 2^(row bits + word-column bits, each at least 1) words
// (192 by default). The back end carries out one item at a time, each word a
// read-modify-write; the two-entry queue lets the front end take more items meanwhile.
// After reset the store is swept to zero, and no item is taken until the sweep ends.
`default_nettype none

module bitplane_glyph_framebuffer_top
  import bgfb_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bgfb_in_if.sink    in_chan,
  bgfb_out_if.source out_chan
);

  cmd_t fe_cmd;
  cmd_t q_head;
  logic fe_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  logic init_busy;

  // Decode and check items
  bgfb_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (fe_push),
    .cmd       (fe_cmd)
  );

  // Decouple front and back
  bgfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .push_cmd (fe_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Carry out commands on the store
  bgfb_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .init_busy (init_busy),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

[hw/rtl/bgfb_checker.sv]
// Port-level checks for the frame buffer top level, bound to it below.
// Depends only on the top level's ports.
`default_nettype none

module bgfb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] read_word,
  input wire logic        out_of_range
);

  logic [2:0] open_r;

  // Count items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_word) && $stable(out_of_range))
    else $error("result changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> read_word == 16'h0000)
    else $error("out-of-range result carries a word");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 3'd0)
    else $error("result with no item outstanding");

  a_init_block: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("item accepted during store clearing after reset");

endmodule

bind bitplane_glyph_framebuffer_top bgfb_checker u_bgfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .read_word    (out_chan.read_word),
  .out_of_range (out_chan.out_of_range)
);

`default_nettype wire
